### hdl/cpx_pkg.sv
`default_nettype none

package cpx_pkg;

    localparam int PWM_BITS      = 8;
    localparam int NUM_LEDS      = 12;
    localparam int LEDS_PER_ROW  = 3;
    localparam int NUM_PINS      = 4;
    localparam int NUM_ROWS      = NUM_PINS;
    localparam int BRIGHT_W      = 8;
    localparam int INDEX_W       = 4;
    localparam int PHASE_W       = 2;
    localparam int COL_W         = 2;
    localparam int CMP_W         = (PWM_BITS > BRIGHT_W) ? PWM_BITS : BRIGHT_W;

    // request codes
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef logic [PWM_BITS-1:0]                       pwm_count_t;
    typedef logic [BRIGHT_W-1:0]                       bright_t;
    typedef logic [CMP_W-1:0]                          cmp_t;
    typedef logic [PHASE_W-1:0]                        phase_t;
    typedef logic [COL_W-1:0]                          col_t;
    typedef logic [INDEX_W-1:0]                        led_index_t;
    typedef logic [NUM_PINS-1:0]                       pin_mask_t;
    typedef logic [NUM_ROWS-1:0][LEDS_PER_ROW-1:0][BRIGHT_W-1:0] bright_store_t;

    // scan state carried from one tick to the next
    typedef struct packed {
        pwm_count_t counter;
        phase_t     phase;
        pin_mask_t  drive;
        pin_mask_t  level;
    } scan_state_t;

    // LED index -> row (low pin phase) and column; LED n sits at row n/3, column n%3
    typedef struct packed {
        logic   hit;
        phase_t row;
        col_t   col;
    } led_slot_t;

    function automatic led_slot_t led_slot(input led_index_t idx);
        led_slot_t s;
        s.hit = 1'b1;
        unique case (idx)
            4'd0:    begin s.row = 2'd0; s.col = 2'd0; end
            4'd1:    begin s.row = 2'd0; s.col = 2'd1; end
            4'd2:    begin s.row = 2'd0; s.col = 2'd2; end
            4'd3:    begin s.row = 2'd1; s.col = 2'd0; end
            4'd4:    begin s.row = 2'd1; s.col = 2'd1; end
            4'd5:    begin s.row = 2'd1; s.col = 2'd2; end
            4'd6:    begin s.row = 2'd2; s.col = 2'd0; end
            4'd7:    begin s.row = 2'd2; s.col = 2'd1; end
            4'd8:    begin s.row = 2'd2; s.col = 2'd2; end
            4'd9:    begin s.row = 2'd3; s.col = 2'd0; end
            4'd10:   begin s.row = 2'd3; s.col = 2'd1; end
            4'd11:   begin s.row = 2'd3; s.col = 2'd2; end
            default: begin s.hit = 1'b0; s.row = 2'd0; s.col = 2'd0; end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### hdl/cpx_req_if.sv
`default_nettype none

interface cpx_req_if
    import cpx_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       req_type;
    led_index_t led_index;
    bright_t    brightness;

    modport source (output valid, req_type, led_index, brightness, input ready);
    modport sink   (input valid, req_type, led_index, brightness, output ready);
endinterface

`default_nettype wire

### hdl/cpx_pin_if.sv
`default_nettype none

interface cpx_pin_if
    import cpx_pkg::*;
;
    logic      valid;
    logic      ready;
    pin_mask_t pin_drive;
    pin_mask_t pin_level;

    modport source (output valid, pin_drive, pin_level, input ready);
    modport sink   (input valid, pin_drive, pin_level, output ready);
endinterface

`default_nettype wire

### hdl/charlieplex_pwm_led_scanner.sv
// A tick transfer on req passes through the input register and then the result
//   register before its pin state shows on pins; a full result register with
//   pins.ready low holds the tick in the input register.
// Throughput: one item per cycle; a write takes a slot but makes no result.
//   A tick stalls only while the result register is full and pins.ready is low.
// Reset (rst_n low, asynchronous): counter, phase, scan pin masks and all twelve
//   brightness values clear to zero; pins.valid drops, result masks not reset.
`default_nettype none

module charlieplex_pwm_led_scanner
    import cpx_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    cpx_req_if.sink    req,
    cpx_pin_if.source  pins
);

    // Input stage: holds one accepted item until it can be processed.
    logic          in_valid_reg,   in_valid_next;
    logic          in_type_reg;
    led_index_t    in_index_reg;
    bright_t       in_bright_reg;

    // Scan state and brightness store (store is 4 rows of 3, row = low pin).
    scan_state_t   scan_reg,       scan_next;
    bright_store_t store_reg;

    // Result register.
    logic          out_valid_reg,  out_valid_next;
    pin_mask_t     out_drive_reg;
    pin_mask_t     out_level_reg;

    logic          is_tick;
    logic          advance;
    logic          take_in;
    led_slot_t     slot;

    assign is_tick = (in_type_reg == REQ_TICK);

    // A write retires without needing the result slot; a tick needs the
    // result register to be empty or emptying this cycle.
    assign advance = in_valid_reg && (!is_tick || !out_valid_reg || pins.ready);
    assign take_in = req.valid && req.ready;

    assign req.ready = !in_valid_reg || advance;

    assign slot = led_slot(in_index_reg);

    cpx_scan_step u_step (
        .cur   (scan_reg),
        .store (store_reg),
        .nxt   (scan_next)
    );

    always_comb
    begin
        in_valid_next = take_in || (in_valid_reg && !advance);

        if (advance && is_tick)
            out_valid_next = 1'b1;
        else if (pins.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            store_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance && is_tick)
                scan_reg <= scan_next;
            // out-of-range LED index is dropped
            if (advance && !is_tick && slot.hit)
                store_reg[slot.row][slot.col] <= in_bright_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_type_reg   <= req.req_type;
            in_index_reg  <= req.led_index;
            in_bright_reg <= req.brightness;
        end
        if (advance && is_tick)
        begin
            out_drive_reg <= scan_next.drive;
            out_level_reg <= scan_next.level;
        end
    end

    assign pins.valid     = out_valid_reg;
    assign pins.pin_drive = out_drive_reg;
    assign pins.pin_level = out_level_reg;

endmodule

`default_nettype wire

### hdl/cpx_scan_step.sv
`default_nettype none

// One PWM tick: phase advance at count zero, then the three LED checks in parallel.
module cpx_scan_step
    import cpx_pkg::*;
(
    input  var scan_state_t   cur,
    input  var bright_store_t store,
    output scan_state_t       nxt
);

    logic      at_zero;
    phase_t    phase_n;
    pin_mask_t drive_n;
    pin_mask_t level_n;

    always_comb
    begin
        logic   [COL_W-1:0] pin_idx;
        logic               skip_low;
        bright_t            val;

        at_zero = (cur.counter == '0);
        phase_n = at_zero ? phase_t'(cur.phase + 1'b1) : cur.phase;

        if (at_zero)
        begin
            drive_n = pin_mask_t'(1) << phase_n;
            level_n = '0;
        end
        else
        begin
            drive_n = cur.drive;
            level_n = cur.level;
        end

        for (int i = 0; i < LEDS_PER_ROW; i++)
        begin
            val      = store[phase_n][i];
            skip_low = (PHASE_W'(i) >= phase_n);
            pin_idx  = COL_W'(i) + COL_W'(skip_low);
            if (at_zero && (val != '0))
            begin
                drive_n[pin_idx] = 1'b1;
                level_n[pin_idx] = 1'b1;
            end
            else if (cmp_t'(val) == cmp_t'(cur.counter))
            begin
                drive_n[pin_idx] = 1'b0;
                level_n[pin_idx] = 1'b0;
            end
        end

        nxt.counter = pwm_count_t'(cur.counter + 1'b1);
        nxt.phase   = phase_n;
        nxt.drive   = drive_n;
        nxt.level   = level_n;
    end

endmodule

`default_nettype wire

### hdl/cpx_checker.sv
`default_nettype none

module cpx_checker
    import cpx_pkg::*;
(
    input wire           clk,
    input wire           rst_n,
    input wire           out_valid,
    input wire           out_ready,
    input var pin_mask_t out_drive,
    input var pin_mask_t out_level
);

    // a released pin never reports high
    a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_level & ~out_drive) == '0))
        else $error("released pin reported high");

    // after any tick exactly one pin is the driven-low phase pin
    a_one_low_pin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones(out_drive & ~out_level) == 1))
        else $error("driven-low pin count is not one");

    // at most one high pin per LED slot: never more than three driven high
    a_high_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones(out_level) <= LEDS_PER_ROW))
        else $error("too many pins driven high");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_drive) && $stable(out_level)))
        else $error("stalled result changed");

endmodule

bind charlieplex_pwm_led_scanner cpx_checker u_cpx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (pins.valid),
    .out_ready (pins.ready),
    .out_drive (pins.pin_drive),
    .out_level (pins.pin_level)
);

`default_nettype wire
